// File: hdl/has_pkg.sv
// Shared types, constants and helpers of the assignment solver.
package has_pkg;

	localparam int MAX_DIM = 16;
	localparam int DIM_W = $clog2(MAX_DIM);
	localparam int CNT_W = DIM_W + 1;
	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = 2 * DIM_W;
	localparam int COST_W = 32;
	localparam int IN_COST_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PAD,
		ST_SUB,
		ST_SUB_END,
		ST_STAR,
		ST_STAR_END,
		ST_CHECK,
		ST_FIND,
		ST_FIND_END,
		ST_PRIME,
		ST_PATH,
		ST_FLIP,
		ST_ADJ,
		ST_ADJ_END,
		ST_EMIT,
		ST_CLEAR
	} st_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PAD,
		OP_SUB,
		OP_STAR,
		OP_FIND,
		OP_ADJ
	} op_t;

	typedef struct packed {
		op_t  op;
		logic load_en;
		logic prime;
		logic path_step;
		logic flip;
		logic check;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic row_end;
		logic scan_last;
		logic found;
		logic none;
		logic zr_starred;
		logic path_go;
		logic all_starred;
		logic emit_done;
	} sts_t;

	// Clamp a dimension register: zero acts as one, above the store acts as full size.
	function automatic logic [CNT_W-1:0] lim_dim(input logic [CFG_DATA_W-1:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = CNT_W'(MAX_DIM);
		end else begin
			r = CNT_W'(v);
		end
		return r;
	endfunction

endpackage

// File: hdl/has_ram.sv
// Generic simple dual-port RAM with registered read.
module has_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/has_dp.sv
// Datapath of the assignment solver: cost store, marks, covers, path walk, pair output.
module has_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  has_pkg::cmd_t                 cmd,
	output has_pkg::sts_t                 sts,
	input  logic [has_pkg::CNT_W-1:0]     rows,
	input  logic [has_pkg::CNT_W-1:0]     cols,
	input  logic [has_pkg::CNT_W-1:0]     n,
	input  logic                          in_valid,
	input  logic [has_pkg::DIM_W-1:0]     row,
	input  logic [has_pkg::DIM_W-1:0]     column,
	input  logic [has_pkg::IN_COST_W-1:0] cost,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [has_pkg::DIM_W-1:0]     assigned_row,
	output logic [has_pkg::DIM_W-1:0]     assigned_column,
	output logic                          final_pair
);

	localparam int D = has_pkg::MAX_DIM;
	localparam int DW = has_pkg::DIM_W;
	localparam int CW = has_pkg::CNT_W;
	localparam int AW = has_pkg::ADDR_W;
	localparam int VW = has_pkg::COST_W;

	// scan counters
	logic [DW-1:0] r_q, c_q;
	logic          done_q;
	logic          issue, row_end, scan_last;
	logic [AW-1:0] raddr;

	// read stage
	logic          v_s1, rowend_s1, last_s1, byp_s1, cv_s1;
	has_pkg::op_t  op_s1;
	logic [DW-1:0] r_s1, c_s1;
	logic [VW-1:0] bypd_s1, rd, d;

	// write port
	logic          ld, s_we, we;
	logic [VW-1:0] s_wv, wd;
	logic [AW-1:0] wa;

	logic [has_pkg::CELLS-1:0] cv_q;
	logic [VW-1:0]             min_q, base, pad_v, sat;
	logic [VW:0]               sum;
	logic                      rcov, ccov, unc, hit_now, hit_any, found, none, star_now;
	logic                      hit_q;
	logic [DW-1:0]             zr_q, zc_q;

	// marks: one star and one prime per row at most
	logic [D-1:0]  rc_q, cc_q, sv_q, pv_q;
	logic [DW-1:0] sc_q [D];
	logic [DW-1:0] pc_q [D];
	logic [D-1:0]  cc_star, mask_q, row_in_n;
	logic [DW-1:0] cur_q, pr;
	logic          p_hit;

	// emission
	logic [DW-1:0] e_q;
	logic [D-1:0]  em, low;
	logic          slot_free, fin;

	has_ram #(.WIDTH(VW), .DEPTH(has_pkg::CELLS)) u_cost (
		.clk   (clk),
		.we    (we),
		.waddr (wa),
		.wdata (wd),
		.raddr (raddr),
		.rdata (rd)
	);

	assign issue = (cmd.op != has_pkg::OP_NONE) && !done_q;
	assign raddr = {r_q, c_q};
	assign row_end = issue && ({1'b0, c_q} == n - CW'(1));
	assign scan_last = row_end && ({1'b0, r_q} == n - CW'(1)) && (cmd.op != has_pkg::OP_PAD);

	always_comb begin
		d = byp_s1 ? bypd_s1 : (cv_s1 ? rd : '0);
		rcov = rc_q[r_s1];
		ccov = cc_q[c_s1];
		unc = !rcov && !ccov;
		pad_v = (({1'b0, r_s1} >= rows) || ({1'b0, c_s1} >= cols)) ? '0 : d;
		sum = {1'b0, d} + {1'b0, min_q};
		sat = sum[VW] ? '1 : sum[VW-1:0];
		hit_now = v_s1 && (op_s1 == has_pkg::OP_FIND) && unc && (d == '0);
		hit_any = hit_q || hit_now;
		found = v_s1 && (op_s1 == has_pkg::OP_FIND) && rowend_s1 && hit_any;
		none = v_s1 && (op_s1 == has_pkg::OP_FIND) && last_s1 && !hit_any;
		base = ((r_s1 == '0) && (c_s1 == '0)) ? '1 : min_q;
		star_now = v_s1 && (op_s1 == has_pkg::OP_STAR) && (d == '0) && unc;
		s_we = 1'b0;
		s_wv = d;
		case (op_s1)
			has_pkg::OP_PAD: begin
				s_we = v_s1;
				s_wv = pad_v;
			end
			has_pkg::OP_SUB: begin
				s_we = v_s1;
				s_wv = d - min_q;
			end
			has_pkg::OP_ADJ: begin
				if (rcov && ccov) begin
					s_we = v_s1;
					s_wv = sat;
				end else if (unc) begin
					s_we = v_s1;
					s_wv = d - min_q;
				end
			end
			default: begin
				s_we = 1'b0;
			end
		endcase
		ld = in_valid && cmd.load_en;
		we = ld || s_we;
		wa = ld ? {row, column} : {r_s1, c_s1};
		wd = ld ? VW'(cost) : s_wv;
	end

	// scan counters and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
			done_q <= 1'b0;
			v_s1 <= 1'b0;
			byp_s1 <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.op == has_pkg::OP_NONE) begin
				r_q <= '0;
				c_q <= '0;
				done_q <= 1'b0;
			end else if (issue) begin
				if (row_end) begin
					c_q <= '0;
					if (scan_last) begin
						r_q <= '0;
						done_q <= 1'b1;
					end else if (cmd.op != has_pkg::OP_PAD) begin
						r_q <= r_q + DW'(1);
					end
				end else begin
					c_q <= c_q + DW'(1);
				end
			end
			// drop the speculative read behind a found zero
			v_s1 <= issue && !found;
			byp_s1 <= we && (wa == raddr);
			if (cmd.op == has_pkg::OP_NONE) begin
				hit_q <= 1'b0;
			end else if (v_s1 && (op_s1 == has_pkg::OP_FIND)) begin
				hit_q <= rowend_s1 ? 1'b0 : hit_any;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= cmd.op;
		r_s1 <= r_q;
		c_s1 <= c_q;
		rowend_s1 <= row_end;
		last_s1 <= scan_last;
		bypd_s1 <= wd;
		cv_s1 <= cv_q[raddr];
		if (v_s1 && (op_s1 == has_pkg::OP_PAD)) begin
			min_q <= ((c_s1 == '0) || (pad_v < min_q)) ? pad_v : min_q;
		end else if (v_s1 && (op_s1 == has_pkg::OP_FIND)) begin
			min_q <= (unc && (d < base)) ? d : base;
		end
		if (hit_now) begin
			zc_q <= c_s1;
		end
		if (found) begin
			zr_q <= r_s1;
		end
	end

	// cell written flags stand in for clearing the cost store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q <= '0;
		end else if (cmd.clear) begin
			cv_q <= '0;
		end else if (we) begin
			cv_q[wa] <= 1'b1;
		end
	end

	always_comb begin
		cc_star = '0;
		for (int c = 0; c < D; c++) begin
			for (int r = 0; r < D; r++) begin
				if (sv_q[r] && (sc_q[r] == DW'(c))) begin
					cc_star[c] = 1'b1;
				end
			end
		end
		for (int r = 0; r < D; r++) begin
			row_in_n[r] = (CW'(r) < n);
		end
		p_hit = 1'b0;
		pr = '0;
		for (int r = D - 1; r >= 0; r--) begin
			if (sv_q[r] && (sc_q[r] == cur_q)) begin
				p_hit = 1'b1;
				pr = DW'(r);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			cc_q <= '0;
			sv_q <= '0;
			pv_q <= '0;
		end else begin
			if (star_now) begin
				rc_q[r_s1] <= 1'b1;
				cc_q[c_s1] <= 1'b1;
				sv_q[r_s1] <= 1'b1;
			end
			if (cmd.check) begin
				rc_q <= '0;
				cc_q <= cc_star;
			end
			if (cmd.prime) begin
				pv_q[zr_q] <= 1'b1;
				if (sv_q[zr_q]) begin
					rc_q[zr_q] <= 1'b1;
					cc_q[sc_q[zr_q]] <= 1'b0;
				end
			end
			if (cmd.flip) begin
				for (int r = 0; r < D; r++) begin
					if (mask_q[r]) begin
						sv_q[r] <= pv_q[r];
					end
				end
				pv_q <= '0;
				rc_q <= '0;
				cc_q <= '0;
			end
			if (cmd.clear) begin
				sv_q <= '0;
				pv_q <= '0;
				rc_q <= '0;
				cc_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (star_now) begin
			sc_q[r_s1] <= c_s1;
		end
		if (cmd.prime) begin
			pc_q[zr_q] <= zc_q;
			if (!sv_q[zr_q]) begin
				mask_q <= D'(1) << zr_q;
				cur_q <= zc_q;
			end
		end
		if (cmd.path_step && p_hit) begin
			mask_q[pr] <= 1'b1;
			if (pv_q[pr]) begin
				cur_q <= pc_q[pr];
			end
		end
		if (cmd.flip) begin
			for (int r = 0; r < D; r++) begin
				if (mask_q[r]) begin
					sc_q[r] <= pc_q[r];
				end
			end
		end
	end

	// pair output
	always_comb begin
		for (int r = 0; r < D; r++) begin
			em[r] = sv_q[r] && (CW'(r) < rows) && ({1'b0, sc_q[r]} < cols);
		end
		low = D'(((D + 1)'(2)) << e_q) - D'(1);
		fin = ((em & ~low) == '0);
		slot_free = !out_valid || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (!cmd.emit) begin
				e_q <= '0;
			end else if (slot_free) begin
				e_q <= e_q + DW'(1);
			end
			if (slot_free) begin
				out_valid <= cmd.emit && em[e_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && cmd.emit) begin
			assigned_row <= e_q;
			assigned_column <= sc_q[e_q];
			final_pair <= fin;
		end
	end

	always_comb begin
		sts.row_end = row_end;
		sts.scan_last = scan_last;
		sts.found = found;
		sts.none = none;
		sts.zr_starred = sv_q[zr_q];
		sts.path_go = p_hit && pv_q[pr];
		sts.all_starred = ((sv_q | ~row_in_n) == '1);
		sts.emit_done = cmd.emit && slot_free && ({1'b0, e_q} == rows - CW'(1));
	end

endmodule

// File: hdl/has_ctrl.sv
// Sequencer of the assignment solver.
module has_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  has_pkg::sts_t sts,
	output has_pkg::cmd_t cmd
);

	has_pkg::st_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= has_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			has_pkg::ST_IDLE: begin
				if (start) state_d = has_pkg::ST_PAD;
			end
			has_pkg::ST_PAD: begin
				if (sts.row_end) state_d = has_pkg::ST_SUB;
			end
			has_pkg::ST_SUB: begin
				if (sts.scan_last) state_d = has_pkg::ST_SUB_END;
				else if (sts.row_end) state_d = has_pkg::ST_PAD;
			end
			has_pkg::ST_SUB_END: state_d = has_pkg::ST_STAR;
			has_pkg::ST_STAR: begin
				if (sts.scan_last) state_d = has_pkg::ST_STAR_END;
			end
			has_pkg::ST_STAR_END: state_d = has_pkg::ST_CHECK;
			has_pkg::ST_CHECK: begin
				state_d = sts.all_starred ? has_pkg::ST_EMIT : has_pkg::ST_FIND;
			end
			has_pkg::ST_FIND: begin
				if (sts.found) state_d = has_pkg::ST_PRIME;
				else if (sts.none) state_d = has_pkg::ST_FIND_END;
			end
			has_pkg::ST_FIND_END: state_d = has_pkg::ST_ADJ;
			has_pkg::ST_PRIME: begin
				state_d = sts.zr_starred ? has_pkg::ST_FIND : has_pkg::ST_PATH;
			end
			has_pkg::ST_PATH: begin
				if (!sts.path_go) state_d = has_pkg::ST_FLIP;
			end
			has_pkg::ST_FLIP: state_d = has_pkg::ST_CHECK;
			has_pkg::ST_ADJ: begin
				if (sts.scan_last) state_d = has_pkg::ST_ADJ_END;
			end
			has_pkg::ST_ADJ_END: state_d = has_pkg::ST_FIND;
			has_pkg::ST_EMIT: begin
				if (sts.emit_done) state_d = has_pkg::ST_CLEAR;
			end
			has_pkg::ST_CLEAR: state_d = has_pkg::ST_IDLE;
			default: state_d = has_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.op = has_pkg::OP_NONE;
		case (state_q)
			has_pkg::ST_IDLE:  cmd.load_en = 1'b1;
			has_pkg::ST_PAD:   cmd.op = has_pkg::OP_PAD;
			has_pkg::ST_SUB:   cmd.op = has_pkg::OP_SUB;
			has_pkg::ST_STAR:  cmd.op = has_pkg::OP_STAR;
			has_pkg::ST_CHECK: cmd.check = 1'b1;
			has_pkg::ST_FIND:  cmd.op = has_pkg::OP_FIND;
			has_pkg::ST_PRIME: cmd.prime = 1'b1;
			has_pkg::ST_PATH:  cmd.path_step = 1'b1;
			has_pkg::ST_FLIP:  cmd.flip = 1'b1;
			has_pkg::ST_ADJ:   cmd.op = has_pkg::OP_ADJ;
			has_pkg::ST_EMIT:  cmd.emit = 1'b1;
			has_pkg::ST_CLEAR: cmd.clear = 1'b1;
			default:           cmd.op = has_pkg::OP_NONE;
		endcase
	end

endmodule

// File: hdl/hungarian_assignment_solver.sv
// Top level of the minimum-cost assignment solver.
//
// Load a cost matrix one beat per cycle while idle on the input channel (row, column,
// cost); the beat with last set stores its entry and starts the solve. While
// solving, in_stall stays high. row_count and column_count are to be written
// through the cfg port only while the block is idle; the block itself does not
// enforce this. 0 acts as 1, values above 16 act as 16. The solve pads the
// problem to n x n with zero cost, n the larger dimension, and scans the cost
// RAM one cell per cycle through its single read port for row reduction,
// starring, each zero search and each adjust pass; path steps walk the marks.
// Then the starred pairs inside the used region leave in row-major order, one
// beat per cycle at most while the output is not stalled, final_pair set on the last.
// A stall on the output holds the current beat and freezes emission.
// At the end the cost store, marks and covers clear in a single state, and the block
// takes input again. Reset leaves the block idle with both counts at 16 and an
// all-zero cost store.
module hungarian_assignment_solver (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [has_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [has_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [has_pkg::DIM_W-1:0]      row,
	input  logic [has_pkg::DIM_W-1:0]      column,
	input  logic [has_pkg::IN_COST_W-1:0]  cost,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [has_pkg::DIM_W-1:0]      assigned_row,
	output logic [has_pkg::DIM_W-1:0]      assigned_column,
	output logic                           final_pair
);

	logic [has_pkg::CFG_DATA_W-1:0] row_count_q, column_count_q;
	logic [has_pkg::CNT_W-1:0]      rows, cols, n;
	has_pkg::cmd_t                  cmd;
	has_pkg::sts_t                  sts;
	logic                           start;

	// register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= has_pkg::CFG_DATA_W'(has_pkg::MAX_DIM);
			column_count_q <= has_pkg::CFG_DATA_W'(has_pkg::MAX_DIM);
		end else if (cfg_write) begin
			case (cfg_index)
				has_pkg::REG_ROW_COUNT:    row_count_q <= cfg_data;
				has_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// effective dimensions and square size
	assign rows = has_pkg::lim_dim(row_count_q);
	assign cols = has_pkg::lim_dim(column_count_q);
	assign n = (rows > cols) ? rows : cols;

	// accept input only when idle
	assign in_stall = !cmd.load_en;
	assign start = in_valid && !in_stall && last;

	has_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd)
	);

	has_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.rows            (rows),
		.cols            (cols),
		.n               (n),
		.in_valid        (in_valid),
		.row             (row),
		.column          (column),
		.cost            (cost),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.assigned_row    (assigned_row),
		.assigned_column (assigned_column),
		.final_pair      (final_pair)
	);

endmodule

// File: test/tb_hungarian_assignment_solver.sv
// Self-checking testbench of the Munkres assignment solver: directed and random cost matrices.
module tb_hungarian_assignment_solver;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM = has_pkg::MAX_DIM;
	localparam int DIM_W = has_pkg::DIM_W;
	localparam int CFG_IDX_W = has_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = has_pkg::CFG_DATA_W;
	localparam int IN_COST_W = has_pkg::IN_COST_W;
	localparam int IDLE_PCT = 34;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PATH_LEN = 2 * MAX_DIM + 2;

	typedef enum bit [1:0] {MK_NONE, MK_STAR, MK_PRIME} mark_t;

	// One table row: either a register setting or a cost beat. Typed rows carry
	// the single pair that the solve must return.
	typedef struct {
		bit        setup;
		bit [4:0]  rows_raw;
		bit [4:0]  cols_raw;
		bit [3:0]  r;
		bit [3:0]  c;
		bit [15:0] cost;
		bit        last;
		bit        typed;
		bit [3:0]  tr;
		bit [3:0]  tc;
	} beat_t;

	typedef struct {
		bit [3:0] r;
		bit [3:0] c;
		bit       fin;
	} pair_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [DIM_W-1:0]      row = '0;
	logic [DIM_W-1:0]      column = '0;
	logic [IN_COST_W-1:0]  cost = '0;
	logic                  last = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [DIM_W-1:0]      assigned_row;
	logic [DIM_W-1:0]      assigned_column;
	logic                  final_pair;

	hungarian_assignment_solver uut (.*);

	// Predictor state: its own copy of the cost matrix, marks, covers and counts.
	int unsigned cost_m[MAX_DIM][MAX_DIM];
	mark_t       mark_m[MAX_DIM][MAX_DIM];
	bit          row_cov[MAX_DIM];
	bit          col_cov[MAX_DIM];
	bit [4:0]    rows_reg = 5'd16;
	bit [4:0]    cols_reg = 5'd16;

	beat_t beat_q[$];
	pair_t pair_q[$];
	beat_t cur_beat;
	beat_t nxt;
	int    errors = 0;
	int    sent = 0;
	bit    quiet = 1'b0;
	bit    hold_go = 1'b0;
	int    hold_left = 0;
	int    still = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int clamp_dim(bit [4:0] v);
		if (v == 0) return 1;
		if (v > MAX_DIM) return MAX_DIM;
		return int'(v);
	endfunction

	function automatic void uncover();
		for (int i = 0; i < MAX_DIM; i++) begin
			row_cov[i] = 0;
			col_cov[i] = 0;
		end
	endfunction

	function automatic int mark_col(int n, int r, mark_t m);
		for (int c = 0; c < n; c++)
			if (mark_m[r][c] == m) return c;
		return -1;
	endfunction

	function automatic int star_row(int n, int c);
		for (int r = 0; r < n; r++)
			if (mark_m[r][c] == MK_STAR) return r;
		return -1;
	endfunction

	// Pick the last uncovered zero in the first row that holds one.
	function automatic bit open_zero(int n, output int zr, output int zc);
		bit hit;
		zr = 0;
		zc = 0;
		for (int r = 0; r < n; r++) begin
			hit = 0;
			if (row_cov[r]) continue;
			for (int c = 0; c < n; c++)
				if (!col_cov[c] && cost_m[r][c] == 0) begin
					zr = r;
					zc = c;
					hit = 1;
				end
			if (hit) return 1;
		end
		return 0;
	endfunction

	// Shift the smallest uncovered value: subtract it from open cells, add it
	// to doubly covered ones (saturating).
	function automatic void adjust_min(int n);
		int unsigned m;
		longint sum;
		m = 32'hFFFF_FFFF;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (!row_cov[r] && !col_cov[c] && cost_m[r][c] < m) m = cost_m[r][c];
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (row_cov[r] && col_cov[c]) begin
					sum = longint'(cost_m[r][c]) + longint'(m);
					cost_m[r][c] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
				end else if (!row_cov[r] && !col_cov[c]) begin
					cost_m[r][c] -= m;
				end
	endfunction

	// Walk the alternating star/prime path from the new prime and flip it.
	function automatic void flip_path(int n, int zr, int zc);
		int pr[PATH_LEN];
		int pc[PATH_LEN];
		int k, r, c;
		k = 0;
		pr[0] = zr;
		pc[0] = zc;
		while (1) begin
			r = star_row(n, pc[k]);
			if (r < 0 || k + 2 >= PATH_LEN) break;
			k++;
			pr[k] = r;
			pc[k] = pc[k-1];
			c = mark_col(n, r, MK_PRIME);
			if (c < 0) break;
			k++;
			pr[k] = r;
			pc[k] = c;
		end
		for (int i = 0; i <= k; i++)
			mark_m[pr[i]][pc[i]] = (mark_m[pr[i]][pc[i]] == MK_STAR) ? MK_NONE : MK_STAR;
		uncover();
		for (int i = 0; i < MAX_DIM; i++)
			for (int j = 0; j < MAX_DIM; j++)
				if (mark_m[i][j] == MK_PRIME) mark_m[i][j] = MK_NONE;
	endfunction

	function automatic void munkres(int rows, int cols);
		int n, stars, zr, zc, sc;
		int unsigned mn;
		n = (rows > cols) ? rows : cols;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++)
				if (r >= rows || c >= cols) cost_m[r][c] = 0;
			mn = cost_m[r][0];
			for (int c = 1; c < n; c++)
				if (cost_m[r][c] < mn) mn = cost_m[r][c];
			for (int c = 0; c < n; c++) cost_m[r][c] -= mn;
		end
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (cost_m[r][c] == 0 && !row_cov[r] && !col_cov[c]) begin
					mark_m[r][c] = MK_STAR;
					row_cov[r] = 1;
					col_cov[c] = 1;
				end
		uncover();
		while (1) begin
			stars = 0;
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++)
					if (mark_m[r][c] == MK_STAR) begin
						col_cov[c] = 1;
						stars++;
					end
			if (stars >= n) break;
			while (1) begin
				if (!open_zero(n, zr, zc)) begin
					adjust_min(n);
					continue;
				end
				mark_m[zr][zc] = MK_PRIME;
				sc = mark_col(n, zr, MK_STAR);
				if (sc >= 0) begin
					row_cov[zr] = 1;
					col_cov[sc] = 0;
				end else begin
					flip_path(n, zr, zc);
					break;
				end
			end
		end
	endfunction

	// Store one accepted cost beat; on last, solve and queue the assignment pairs.
	function automatic void predict_pairs(beat_t b);
		int rows, cols, total, k;
		pair_t p;
		pair_t found[$];
		cost_m[b.r][b.c] = 32'(b.cost);
		if (!b.last) return;
		rows = clamp_dim(rows_reg);
		cols = clamp_dim(cols_reg);
		munkres(rows, cols);
		total = 0;
		for (int i = 0; i < rows; i++)
			for (int j = 0; j < cols; j++)
				if (mark_m[i][j] == MK_STAR) total++;
		k = 0;
		for (int i = 0; i < rows; i++)
			for (int j = 0; j < cols; j++)
				if (mark_m[i][j] == MK_STAR && k < 16) begin
					p.r = 4'(i);
					p.c = 4'(j);
					p.fin = (k + 1 == total);
					found.insert(found.size(), p);
					k++;
				end
		if (b.typed) begin
			p.r = b.tr;
			p.c = b.tc;
			p.fin = 1;
			pair_q.insert(pair_q.size(), p);
		end else begin
			foreach (found[i]) pair_q.insert(pair_q.size(), found[i]);
		end
		for (int i = 0; i < MAX_DIM; i++)
			for (int j = 0; j < MAX_DIM; j++) begin
				cost_m[i][j] = 0;
				mark_m[i][j] = MK_NONE;
			end
		uncover();
	endfunction

	// Sender: offer queued beats, idle at random; update the predictor on acceptance.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_pairs(cur_beat);
			if (!in_valid || !in_stall) begin
				if (beat_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					nxt = beat_q.pop_front();
					in_valid <= 1'b1;
					row <= nxt.r;
					column <= nxt.c;
					cost <= nxt.cost;
					last <= nxt.last;
					cur_beat <= nxt;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted pair against the oldest expectation. Stall at
	// random, or hold off for a long stretch when asked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pair_q.size() == 0) begin
					$error("unexpected pair row=%0d column=%0d", assigned_row, assigned_column);
					errors++;
				end else begin
					if (assigned_row !== pair_q[0].r) begin
						$error("assigned_row: expected %0d, got %0d", pair_q[0].r, assigned_row);
						errors++;
					end
					if (assigned_column !== pair_q[0].c) begin
						$error("assigned_column: expected %0d, got %0d",
							pair_q[0].c, assigned_column);
						errors++;
					end
					if (final_pair !== pair_q[0].fin) begin
						$error("final_pair: expected %0d, got %0d", pair_q[0].fin, final_pair);
						errors++;
					end
					void'(pair_q.pop_front());
				end
			end
			if (hold_go) begin
				hold_left = HOLD_CYCLES;
				hold_go = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Watchdog: count cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
				still <= 0;
			end else if (still >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end else begin
				still <= still + 1;
			end
		end
	end

	// Wait until every beat is out, every pair back, and the block has cleared.
	task automatic wait_idle();
		do @(posedge clk); while (beat_q.size() != 0 || in_valid || pair_q.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_dims(bit [4:0] r_raw, bit [4:0] c_raw);
		cfg_write <= 1'b1;
		cfg_index <= has_pkg::REG_ROW_COUNT;
		cfg_data <= r_raw;
		@(posedge clk);
		cfg_index <= has_pkg::REG_COLUMN_COUNT;
		cfg_data <= c_raw;
		@(posedge clk);
		cfg_write <= 1'b0;
		rows_reg = r_raw;
		cols_reg = c_raw;
	endtask

	task automatic add_beat(bit [3:0] r, bit [3:0] c, bit [15:0] v, bit lst);
		beat_t b;
		b = '{default: 0};
		b.r = r;
		b.c = c;
		b.cost = v;
		b.last = lst;
		beat_q.insert(beat_q.size(), b);
		sent++;
	endtask

	// Queue one problem: every used cell in shuffled order, some stray cells
	// outside the region or repeated, last set on the final beat.
	task automatic add_problem(bit [4:0] r_raw, bit [4:0] c_raw);
		int rows, cols, mode, stray;
		int cells[$];
		bit [15:0] v;
		rows = clamp_dim(r_raw);
		cols = clamp_dim(c_raw);
		mode = $urandom_range(2);
		for (int i = 0; i < rows * cols; i++) cells.insert(cells.size(), i);
		cells.shuffle();
		stray = $urandom_range(3);
		for (int i = 0; i < cells.size(); i++) begin
			if (stray > 0 && $urandom_range(7) == 0) begin
				add_beat(4'($urandom_range(15)), 4'($urandom_range(15)), 16'($urandom),
					1'b0);
				stray--;
			end
			case (mode)
				0: v = 16'($urandom_range(3));
				1: v = 16'($urandom);
				default: v = 16'($urandom_range(40));
			endcase
			add_beat(4'(cells[i] / cols), 4'(cells[i] % cols), v, i == cells.size() - 1);
		end
	endtask

	beat_t directed[] = '{
		// all-zero matrix at reset size: diagonal assignment
		'{0, 0, 0, 4'd0, 4'd0, 16'd0, 1, 0, 0, 0},
		// zero counts act as one
		'{1, 5'd0, 5'd0, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd0, 16'hFFFF, 1, 1, 4'd0, 4'd0},
		// entry outside the used region is padded away
		'{1, 5'd1, 5'd1, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd15, 4'd15, 16'd5, 1, 1, 4'd0, 4'd0},
		// more rows than columns: cheapest row wins the single column
		'{1, 5'd3, 5'd1, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd0, 16'd9, 0, 0, 0, 0},
		'{0, 0, 0, 4'd1, 4'd0, 16'd2, 0, 0, 0, 0},
		'{0, 0, 0, 4'd2, 4'd0, 16'd4, 1, 1, 4'd1, 4'd0},
		// tie within a row: first uncovered zero starred
		'{1, 5'd1, 5'd3, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd0, 16'd4, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd1, 16'd1, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd2, 16'd1, 1, 1, 4'd0, 4'd1},
		// counts above the store act as full size; overwrite keeps the later cost
		'{1, 5'd31, 5'd31, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd3, 4'd3, 16'd100, 0, 0, 0, 0},
		'{0, 0, 0, 4'd3, 4'd3, 16'd1, 0, 0, 0, 0},
		'{0, 0, 0, 4'd15, 4'd0, 16'hFFFF, 1, 0, 0, 0},
		// anti-diagonal with extreme costs
		'{1, 5'd2, 5'd2, 0, 0, 0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd0, 16'hFFFF, 0, 0, 0, 0},
		'{0, 0, 0, 4'd0, 4'd1, 16'd0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd1, 4'd0, 16'd0, 0, 0, 0, 0},
		'{0, 0, 0, 4'd1, 4'd1, 16'hFFFF, 1, 0, 0, 0}
	};

	initial begin
		bit [4:0] r_raw, c_raw;
		int p;
		for (int i = 0; i < MAX_DIM; i++)
			for (int j = 0; j < MAX_DIM; j++) begin
				cost_m[i][j] = 0;
				mark_m[i][j] = MK_NONE;
			end
		uncover();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: settings only once the block has gone quiet.
		foreach (directed[i]) begin
			if (directed[i].setup) begin
				wait_idle();
				write_dims(directed[i].rows_raw, directed[i].cols_raw);
			end else begin
				beat_q.insert(beat_q.size(), directed[i]);
				sent++;
			end
		end

		// Random problems: mostly small, one with sixteen rows, a few clamped counts.
		p = 0;
		while (sent < 250 || p < 10) begin
			wait_idle();
			quiet = (p >= 6 && p < 10);
			if (p == 3) begin
				r_raw = 5'd16;
				c_raw = 5'd4;
			end else begin
				r_raw = 5'($urandom_range(1, 5));
				c_raw = 5'($urandom_range(1, 5));
				case ($urandom_range(9))
					0: r_raw = 5'd0;
					1: c_raw = 5'($urandom_range(17, 31));
					default: ;
				endcase
			end
			write_dims(r_raw, c_raw);
			if (p == 8) begin
				// Hold the receiver while two problems queue up behind each other.
				hold_go = 1;
				add_problem(r_raw, c_raw);
				add_problem(r_raw, c_raw);
			end else begin
				add_problem(r_raw, c_raw);
			end
			p++;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
